/* hw/rtl/mrrc_pkg.sv */
// Shared types, constants and the CRC-16/Modbus byte update for the reply checker.
package mrrc_pkg;

    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'hA001;
    localparam logic [3:0]  CRC_BYTES = 4'd5;
    localparam logic [3:0]  FRAME_LEN = 4'd7;
    localparam logic [3:0]  COUNT_MAX = 4'd8;

    // Frame positions of the payload and CRC bytes.
    localparam logic [3:0]  POS_VALUE_HIGH = 4'd3;
    localparam logic [3:0]  POS_VALUE_LOW  = 4'd4;
    localparam logic [3:0]  POS_CRC_LOW    = 4'd5;
    localparam logic [3:0]  POS_CRC_HIGH   = 4'd6;

    localparam logic signed [15:0] ERROR_VALUE = -16'sd1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TOO_SHORT = 2'd1,
        ST_TOO_LONG  = 2'd2,
        ST_BAD_CRC   = 2'd3
    } t_status;

    // One judged frame.
    typedef struct packed {
        t_status            status;
        logic signed [15:0] value;
    } t_result;

    // Reflected CRC-16 update over one byte, eight shift steps unrolled.
    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

/* hw/rtl/mrrc_frame.sv */
// Frame state, CRC accumulation and end-of-frame judgment.
module mrrc_frame
    import mrrc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_fire,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_byte_present,
    input  logic        i_frame_end,
    output logic        o_result_valid,
    output t_result     o_result
);

    logic [3:0]  r_count;
    logic [15:0] r_crc;
    logic [7:0]  r_value_high;
    logic [7:0]  r_value_low;
    logic [15:0] r_rx_crc;

    logic [3:0]  n_count;
    logic [15:0] n_crc;
    logic [7:0]  n_value_high;
    logic [7:0]  n_value_low;
    logic [15:0] n_rx_crc;

    // Take the byte into the frame state.
    always_comb begin
        n_count      = r_count;
        n_crc        = r_crc;
        n_value_high = r_value_high;
        n_value_low  = r_value_low;
        n_rx_crc     = r_rx_crc;
        if (i_byte_present) begin
            if (r_count < CRC_BYTES) begin
                n_crc = crc_update(r_crc, i_rx_byte);
            end
            unique case (r_count)
                POS_VALUE_HIGH: n_value_high   = i_rx_byte;
                POS_VALUE_LOW:  n_value_low    = i_rx_byte;
                POS_CRC_LOW:    n_rx_crc[7:0]  = i_rx_byte;
                POS_CRC_HIGH:   n_rx_crc[15:8] = i_rx_byte;
                default: ;
            endcase
            if (r_count < COUNT_MAX) begin
                n_count = r_count + 4'd1;
            end
        end
    end

    // Judge the frame including the byte that came with the end mark.
    always_comb begin
        priority if (n_count < FRAME_LEN) begin
            o_result.status = ST_TOO_SHORT;
        end else if (n_count > FRAME_LEN) begin
            o_result.status = ST_TOO_LONG;
        end else if (n_rx_crc != n_crc) begin
            o_result.status = ST_BAD_CRC;
        end else begin
            o_result.status = ST_OK;
        end
        if (o_result.status == ST_OK) begin
            o_result.value = $signed({n_value_high, n_value_low});
        end else begin
            o_result.value = ERROR_VALUE;
        end
    end

    assign o_result_valid = i_fire && i_frame_end;

    // State update; the frame end returns everything to its start values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_fire && i_frame_end)) begin
            r_count      <= '0;
            r_crc        <= CRC_INIT;
            r_value_high <= '0;
            r_value_low  <= '0;
            r_rx_crc     <= '0;
        end else if (i_fire) begin
            r_count      <= n_count;
            r_crc        <= n_crc;
            r_value_high <= n_value_high;
            r_value_low  <= n_value_low;
            r_rx_crc     <= n_rx_crc;
        end
    end

endmodule

/* hw/rtl/mrrc_out_buf.sv */
// Result output register with a one-entry skid stage.
module mrrc_out_buf
    import mrrc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_result,
    output logic    o_room,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_result
);

    logic    r_main_valid;
    t_result r_main;
    logic    r_skid_valid;
    t_result r_skid;
    logic    pop;

    assign pop      = r_main_valid && !i_stall;
    assign o_room   = !r_skid_valid;
    assign o_valid  = r_main_valid;
    assign o_result = r_main;

    // Refill the main register from the skid stage first, then from new results.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_main       <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (!r_main_valid || pop) begin
            r_main_valid <= i_push;
            if (i_push) begin
                r_main <= i_result;
            end
        end else if (i_push) begin
            r_skid       <= i_result;
            r_skid_valid <= 1'b1;
        end
    end

endmodule

/* hw/rtl/modbus_read_response_checker.sv */
// Top level of the Modbus RTU single-register read reply checker.
// Accepts one request per clock cycle, each carrying an optional received byte and an
// end-of-frame mark, and sustains one request per cycle as long as results are taken.
// A request is held in the input register, where the CRC-16/Modbus update of its byte
// and, on frame end, the judgment run; the result goes into the output main register,
// or into the skid entry while the main one holds a stalled result. The output has a
// main register and one skid entry; o_in_stall rises only while both hold a result,
// and is driven from registers alone. The status gives too short, too long, CRC
// mismatch or ok in that priority; the register value is -1 for any status but ok.
module modbus_read_response_checker
    import mrrc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_rx_byte,
    input  logic               i_byte_present,
    input  logic               i_frame_end,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_frame_status,
    output logic signed [15:0] o_register_value
);

    logic       r_in_valid;
    logic [7:0] r_rx_byte;
    logic       r_byte_present;
    logic       r_frame_end;

    logic       room;
    logic       advance;
    logic       accept;
    logic       result_valid;
    t_result    result;
    t_result    out_result;

    assign advance    = r_in_valid && room;
    assign o_in_stall = r_in_valid && !room;
    assign accept     = i_in_valid && !o_in_stall;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rx_byte      <= i_rx_byte;
            r_byte_present <= i_byte_present;
            r_frame_end    <= i_frame_end;
        end
    end

    mrrc_frame u_frame (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (advance),
        .i_rx_byte      (r_rx_byte),
        .i_byte_present (r_byte_present),
        .i_frame_end    (r_frame_end),
        .o_result_valid (result_valid),
        .o_result       (result)
    );

    mrrc_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (result_valid),
        .i_result (result),
        .o_room   (room),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_result (out_result)
    );

    assign o_frame_status   = out_result.status;
    assign o_register_value = out_result.value;

endmodule

/* hw/rtl/mrrc_checker.sv */
// Port-level assertions for the reply checker and their bind to the top level.
module mrrc_checker
    import mrrc_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [1:0]         o_frame_status,
    input logic signed [15:0] o_register_value
);

    // A stalled result stays and keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_frame_status)
            && $stable(o_register_value))
        else $error("stalled result changed or dropped");

    // Any status but ok carries the error value.
    a_err_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_frame_status != ST_OK) |-> o_register_value == ERROR_VALUE)
        else $error("error status without error value");

    // The input is only held back while a result waits at the output.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with an empty output");

    // Reset empties the block.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("block not empty after reset");

endmodule

bind modbus_read_response_checker mrrc_checker u_mrrc_checker (.*);
